### rtl/i8cv_pkg.sv
// Package for the int8 convolution engine: widths, codes, sequencer states
// and the request/response types of the shared divider. No dependencies.
`default_nettype none

package i8cv_pkg;

    // Default capacities of the on-chip stores.
    localparam int DEF_MAX_HEIGHT      = 32;
    localparam int DEF_MAX_WIDTH       = 32;
    localparam int DEF_MAX_IN_CHANNELS = 16;
    localparam int DEF_MAX_OUT_CHANNELS = 16;
    localparam int DEF_MAX_KERNEL      = 5;

    // Port widths.
    localparam int OP_W       = 2;
    localparam int IDX_W      = 15;
    localparam int VAL_W      = 8;
    localparam int SUM_W      = 24;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    // Configuration register widths.
    localparam int W_IN_H   = 6;
    localparam int W_IN_W   = 6;
    localparam int W_IN_C   = 5;
    localparam int W_OUT_C  = 5;
    localparam int W_FILT_H = 3;
    localparam int W_FILT_W = 3;
    localparam int W_STEP   = 3;
    localparam int W_BORDER = 3;

    // Internal widths: saturated geometry, signed coordinates, store sizes,
    // signed address arithmetic, the divider and the product.
    localparam int GEO_W  = 11;
    localparam int CO_W   = 12;
    localparam int SIZE_W = 26;
    localparam int AD_W   = 28;
    localparam int DIV_W  = 16;
    localparam int PROD_W = 16;

    // Opcodes.
    localparam logic [OP_W-1:0] OP_WEIGHT  = 2'd0;
    localparam logic [OP_W-1:0] OP_FEATURE = 2'd1;
    localparam logic [OP_W-1:0] OP_OUTPUT  = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_GEOM  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IN_H   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_W   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_C   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_C  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILT_H = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILT_W = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER = 3'd7;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SIZE1,
        ST_SIZE2,
        ST_DISPATCH,
        ST_DIV_H,
        ST_DIV_W,
        ST_TOTAL1,
        ST_TOTAL2,
        ST_CHECK,
        ST_DIV_F,
        ST_DIV_P,
        ST_ORIGIN,
        ST_BASE1,
        ST_BASE2,
        ST_MAC,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // Divider request and response.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

### rtl/int8_conv2d_engine.sv
// Int8 2-D convolution engine, channels-last, with stride and zero padding.
// Handles one request at a time. A weight or input write (opcode 0 or 1)
// passes the size steps and the dispatch step. An output request (opcode 2)
// decodes geometry and index on the shared one-bit-per-cycle divider,
// locates the window in the origin and base steps, then walks every channel
// of every kernel tap inside the map, one multiply-accumulate per cycle
// through the single read port of each store, and steps once over each
// kernel position that falls in the padding. It then drains the
// read/multiply pipeline, loads the output register and returns to idle
// before taking the next request. Errors (index past the output count, or
// no output) come back without any MAC work. A finished result waits in an
// output register, so the next request is taken while it is not yet read.
// Depends on i8cv_pkg, i8cv_ram and i8cv_div.
`default_nettype none

module int8_conv2d_engine #(
    parameter int MAX_HEIGHT       = i8cv_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH        = i8cv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_IN_CHANNELS  = i8cv_pkg::DEF_MAX_IN_CHANNELS,
    parameter int MAX_OUT_CHANNELS = i8cv_pkg::DEF_MAX_OUT_CHANNELS,
    parameter int MAX_KERNEL       = i8cv_pkg::DEF_MAX_KERNEL
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Configuration write port.
    input  wire logic                                  cfg_write,
    input  wire logic [i8cv_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [i8cv_pkg::CFG_DATA_W-1:0]       cfg_data,
    // Request channel.
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [i8cv_pkg::OP_W-1:0]             opcode,
    input  wire logic [i8cv_pkg::IDX_W-1:0]            index,
    input  wire logic signed [i8cv_pkg::VAL_W-1:0]     value,
    // Result channel.
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [i8cv_pkg::SUM_W-1:0]          sum,
    output logic [i8cv_pkg::STAT_W-1:0]                status
);
    import i8cv_pkg::*;

    localparam int FEAT_DEPTH = MAX_HEIGHT * MAX_WIDTH * MAX_IN_CHANNELS;
    localparam int FILT_DEPTH = MAX_OUT_CHANNELS * MAX_KERNEL * MAX_KERNEL * MAX_IN_CHANNELS;
    localparam int FEAT_AW    = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
    localparam int FILT_AW    = (FILT_DEPTH > 1) ? $clog2(FILT_DEPTH) : 1;

    // Configuration registers.
    logic [W_IN_H-1:0]   in_h_reg;
    logic [W_IN_W-1:0]   in_w_reg;
    logic [W_IN_C-1:0]   in_c_reg;
    logic [W_OUT_C-1:0]  out_c_reg;
    logic [W_FILT_H-1:0] filt_h_reg;
    logic [W_FILT_W-1:0] filt_w_reg;
    logic [W_STEP-1:0]   step_reg;
    logic [W_BORDER-1:0] border_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_h_reg   <= W_IN_H'(1);
            in_w_reg   <= W_IN_W'(1);
            in_c_reg   <= W_IN_C'(1);
            out_c_reg  <= W_OUT_C'(1);
            filt_h_reg <= W_FILT_H'(1);
            filt_w_reg <= W_FILT_W'(1);
            step_reg   <= W_STEP'(1);
            border_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IN_H:   in_h_reg   <= cfg_data[W_IN_H-1:0];
                CFG_IN_W:   in_w_reg   <= cfg_data[W_IN_W-1:0];
                CFG_IN_C:   in_c_reg   <= cfg_data[W_IN_C-1:0];
                CFG_OUT_C:  out_c_reg  <= cfg_data[W_OUT_C-1:0];
                CFG_FILT_H: filt_h_reg <= cfg_data[W_FILT_H-1:0];
                CFG_FILT_W: filt_w_reg <= cfg_data[W_FILT_W-1:0];
                CFG_STEP:   step_reg   <= cfg_data[W_STEP-1:0];
                CFG_BORDER: border_reg <= cfg_data[W_BORDER-1:0];
                default:    ;
            endcase
        end
    end

    // Geometry saturated to the store capacities; stride and padding are only widened.
    logic [GEO_W-1:0] ih_s, iw_s, ic_s, oc_s, kh_s, kw_s, st_s, pad_s;

    always_comb
    begin
        ih_s  = (GEO_W'(in_h_reg) > GEO_W'(MAX_HEIGHT)) ? GEO_W'(MAX_HEIGHT) : GEO_W'(in_h_reg);
        iw_s  = (GEO_W'(in_w_reg) > GEO_W'(MAX_WIDTH)) ? GEO_W'(MAX_WIDTH) : GEO_W'(in_w_reg);
        ic_s  = (GEO_W'(in_c_reg) > GEO_W'(MAX_IN_CHANNELS)) ?
                GEO_W'(MAX_IN_CHANNELS) : GEO_W'(in_c_reg);
        oc_s  = (GEO_W'(out_c_reg) > GEO_W'(MAX_OUT_CHANNELS)) ?
                GEO_W'(MAX_OUT_CHANNELS) : GEO_W'(out_c_reg);
        kh_s  = (GEO_W'(filt_h_reg) > GEO_W'(MAX_KERNEL)) ?
                GEO_W'(MAX_KERNEL) : GEO_W'(filt_h_reg);
        kw_s  = (GEO_W'(filt_w_reg) > GEO_W'(MAX_KERNEL)) ?
                GEO_W'(MAX_KERNEL) : GEO_W'(filt_w_reg);
        st_s  = GEO_W'(step_reg);
        pad_s = GEO_W'(border_reg);
    end

    // Sequencer and captured request.
    state_t state_reg, state_next;
    logic [OP_W-1:0]  op_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [VAL_W-1:0] val_reg;

    // Derived geometry.
    logic [SIZE_W-1:0] hw_reg, okh_reg, kwic_reg, khkw_reg, rowstride_reg;
    logic [SIZE_W-1:0] feat_size_reg, filt_size_reg, khkwic_reg;
    logic [SIZE_W-1:0] ohow_reg, total_reg;
    logic [CO_W-1:0]   ph_reg, pw_reg;
    logic              nz_reg, geom_ok_reg;
    logic [GEO_W-1:0]  oh_reg, ow_reg;

    // Decoded output position and MAC walk.
    logic [GEO_W-1:0]       f_reg, i_reg, j_reg;
    logic signed [CO_W-1:0] r_reg, col_reg, c0_reg;
    logic [GEO_W-1:0]       k_reg, l_reg, c_reg;
    logic signed [AD_W-1:0] t_reg, fa_row_reg, fa_pix_reg;
    logic [SIZE_W-1:0]      wa_pix_reg;

    // Pipeline and result.
    logic                     iss_reg, pv_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]         acc_reg;
    logic [STAT_W-1:0]        res_status_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]         sum_reg;
    logic [STAT_W-1:0]        status_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic in_accept, out_load;
    logic tap_in_map, last_c, last_l, last_k;
    logic feat_we, filt_we;
    logic [AD_W-1:0]   fa_rd;
    logic [SIZE_W-1:0] wa_rd;
    logic [VAL_W-1:0]  feat_q, filt_q;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);

    // MAC walk conditions.
    always_comb
    begin
        tap_in_map = !r_reg[CO_W-1] && (CO_W'(r_reg) < {1'b0, ih_s}) &&
                     !col_reg[CO_W-1] && (CO_W'(col_reg) < {1'b0, iw_s});
        last_c = (c_reg == ic_s - GEO_W'(1));
        last_l = (l_reg == kw_s - GEO_W'(1));
        last_k = (k_reg == kh_s - GEO_W'(1));
        fa_rd  = fa_pix_reg + AD_W'(c_reg);
        wa_rd  = wa_pix_reg + SIZE_W'(c_reg);
    end

    // Store writes for opcodes 0 and 1; out-of-range indexes are dropped.
    always_comb
    begin
        feat_we = (state_reg == ST_DISPATCH) && (op_reg == OP_FEATURE) &&
                  (SIZE_W'(idx_reg) < feat_size_reg);
        filt_we = (state_reg == ST_DISPATCH) && (op_reg == OP_WEIGHT) &&
                  (ih_s != '0) && (iw_s != '0) && (SIZE_W'(idx_reg) < filt_size_reg);
    end

    // Next state, divider requests and output loading.
    always_comb
    begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(pw_reg);
        div_req.divisor  = DIV_W'(st_s);
        out_load         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_SIZE1;
                end
            end
            ST_SIZE1:
            begin
                state_next = ST_SIZE2;
            end
            ST_SIZE2:
            begin
                state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                if (op_reg != OP_OUTPUT)
                begin
                    state_next = ST_IDLE;
                end
                else if (!geom_ok_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(ph_reg);
                    state_next       = ST_DIV_H;
                end
            end
            ST_DIV_H:
            begin
                if (div_rsp.done)
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_W;
                end
            end
            ST_DIV_W:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_TOTAL1;
                end
            end
            ST_TOTAL1:
            begin
                state_next = ST_TOTAL2;
            end
            ST_TOTAL2:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (SIZE_W'(idx_reg) >= total_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(idx_reg);
                    div_req.divisor  = DIV_W'(oc_s);
                    state_next       = ST_DIV_F;
                end
            end
            ST_DIV_F:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = div_rsp.quotient;
                    div_req.divisor  = DIV_W'(ow_reg);
                    state_next       = ST_DIV_P;
                end
            end
            ST_DIV_P:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_ORIGIN;
                end
            end
            ST_ORIGIN:
            begin
                state_next = ST_BASE1;
            end
            ST_BASE1:
            begin
                state_next = ST_BASE2;
            end
            ST_BASE2:
            begin
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if ((!tap_in_map || last_c) && last_l && last_k)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!iss_reg && !pv_reg)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && out_stall) || out_load;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            iss_reg       <= 1'b0;
            pv_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            iss_reg       <= (state_reg == ST_MAC) && tap_in_map;
            pv_reg        <= iss_reg;
        end
    end

    // Datapath registers, mostly loaded in a particular sequencer step.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg  <= opcode;
            idx_reg <= index;
            val_reg <= value;
        end

        if (state_reg == ST_SIZE1)
        begin
            hw_reg        <= SIZE_W'(ih_s) * SIZE_W'(iw_s);
            okh_reg       <= SIZE_W'(oc_s) * SIZE_W'(kh_s);
            kwic_reg      <= SIZE_W'(kw_s) * SIZE_W'(ic_s);
            khkw_reg      <= SIZE_W'(kh_s) * SIZE_W'(kw_s);
            rowstride_reg <= SIZE_W'(iw_s) * SIZE_W'(ic_s);
            ph_reg        <= {1'b0, ih_s} + {pad_s, 1'b0} - {1'b0, kh_s};
            pw_reg        <= {1'b0, iw_s} + {pad_s, 1'b0} - {1'b0, kw_s};
            nz_reg        <= (ih_s != '0) && (iw_s != '0) && (ic_s != '0) &&
                             (oc_s != '0) && (kh_s != '0) && (kw_s != '0) &&
                             (st_s != '0);
        end

        if (state_reg == ST_SIZE2)
        begin
            feat_size_reg <= hw_reg * SIZE_W'(ic_s);
            filt_size_reg <= okh_reg * kwic_reg;
            khkwic_reg    <= khkw_reg * SIZE_W'(ic_s);
            geom_ok_reg   <= nz_reg && !ph_reg[CO_W-1] && !pw_reg[CO_W-1];
        end

        if ((state_reg == ST_DIV_H) && div_rsp.done)
        begin
            oh_reg <= GEO_W'(div_rsp.quotient + DIV_W'(1));
        end
        if ((state_reg == ST_DIV_W) && div_rsp.done)
        begin
            ow_reg <= GEO_W'(div_rsp.quotient + DIV_W'(1));
        end
        if (state_reg == ST_TOTAL1)
        begin
            ohow_reg <= SIZE_W'(oh_reg) * SIZE_W'(ow_reg);
        end
        if (state_reg == ST_TOTAL2)
        begin
            total_reg <= ohow_reg * SIZE_W'(oc_s);
        end
        if ((state_reg == ST_DIV_F) && div_rsp.done)
        begin
            f_reg <= GEO_W'(div_rsp.remainder);
        end
        if ((state_reg == ST_DIV_P) && div_rsp.done)
        begin
            i_reg <= GEO_W'(div_rsp.quotient);
            j_reg <= GEO_W'(div_rsp.remainder);
        end

        // Result status for the request in flight.
        if (state_reg == ST_DISPATCH)
        begin
            res_status_reg <= STAT_GEOM;
        end
        else if (state_reg == ST_CHECK)
        begin
            res_status_reg <= (SIZE_W'(idx_reg) >= total_reg) ? STAT_RANGE : STAT_OK;
        end

        // Top-left corner of the window and the filter's first weight.
        if (state_reg == ST_ORIGIN)
        begin
            r_reg      <= CO_W'(i_reg) * CO_W'(st_s) - CO_W'(pad_s);
            c0_reg     <= CO_W'(j_reg) * CO_W'(st_s) - CO_W'(pad_s);
            wa_pix_reg <= SIZE_W'(f_reg) * khkwic_reg;
        end
        if (state_reg == ST_BASE1)
        begin
            t_reg <= AD_W'(r_reg) * AD_W'(iw_s) + AD_W'(c0_reg);
        end
        if (state_reg == ST_BASE2)
        begin
            fa_row_reg <= t_reg * AD_W'(ic_s);
            fa_pix_reg <= t_reg * AD_W'(ic_s);
            col_reg    <= c0_reg;
            k_reg      <= '0;
            l_reg      <= '0;
            c_reg      <= '0;
        end

        // Walk channels, then kernel columns, then kernel rows.
        if (state_reg == ST_MAC)
        begin
            if (tap_in_map && !last_c)
            begin
                c_reg <= c_reg + GEO_W'(1);
            end
            else
            begin
                c_reg      <= '0;
                wa_pix_reg <= wa_pix_reg + SIZE_W'(ic_s);
                if (last_l)
                begin
                    l_reg      <= '0;
                    k_reg      <= k_reg + GEO_W'(1);
                    r_reg      <= r_reg + CO_W'(1);
                    col_reg    <= c0_reg;
                    fa_row_reg <= fa_row_reg + AD_W'(rowstride_reg);
                    fa_pix_reg <= fa_row_reg + AD_W'(rowstride_reg);
                end
                else
                begin
                    l_reg      <= l_reg + GEO_W'(1);
                    col_reg    <= col_reg + CO_W'(1);
                    fa_pix_reg <= fa_pix_reg + AD_W'(ic_s);
                end
            end
        end

        // Multiply the registered store outputs, then accumulate.
        prod_reg <= $signed(feat_q) * $signed(filt_q);
        if (state_reg == ST_ORIGIN)
        begin
            acc_reg <= '0;
        end
        else if (pv_reg)
        begin
            acc_reg <= acc_reg + SUM_W'(prod_reg);
        end

        // Output register.
        if (out_load)
        begin
            sum_reg    <= (res_status_reg == STAT_OK) ? acc_reg : '0;
            status_reg <= res_status_reg;
        end
    end

    // Input feature store.
    i8cv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (FEAT_DEPTH)
    ) u_feature_store (
        .clk   (clk),
        .we    (feat_we),
        .waddr (FEAT_AW'(idx_reg)),
        .wdata (val_reg),
        .raddr (fa_rd[FEAT_AW-1:0]),
        .rdata (feat_q)
    );

    // Filter weight store.
    i8cv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (FILT_DEPTH)
    ) u_filter_store (
        .clk   (clk),
        .we    (filt_we),
        .waddr (FILT_AW'(idx_reg)),
        .wdata (val_reg),
        .raddr (wa_rd[FILT_AW-1:0]),
        .rdata (filt_q)
    );

    // Shared divider for geometry and index decoding.
    i8cv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_valid = out_valid_reg;
    assign sum       = sum_reg;
    assign status    = status_reg;

    // An error result always carries a zero sum.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != STAT_OK)) |-> (sum_reg == '0))
        else $error("error result with nonzero sum");

    // Every issued store read reaches the multiplier in the next cycle.
    a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        iss_reg |=> pv_reg)
        else $error("read issue lost in MAC pipeline");

    // The channel counter stays within the configured channel count.
    a_chan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> (c_reg < ic_s))
        else $error("channel counter out of range");

endmodule

`default_nettype wire

### rtl/i8cv_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module i8cv_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/i8cv_div.sv
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// Depends on i8cv_pkg for its width and request/response types.
`default_nettype none

module i8cv_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire i8cv_pkg::div_req_t req,
    output i8cv_pkg::div_rsp_t      rsp
);
    import i8cv_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] divisor_reg;

    logic [DIV_W:0]   shifted;
    logic [DIV_W+1:0] diff;
    logic             fits;

    // Trial subtraction of the divisor from the shifted partial remainder.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_W-1]};
        diff    = {1'b0, shifted} - {2'b00, divisor_reg};
        fits    = !diff[DIV_W+1];
    end

    // Control: start loads the operands, then one step per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    // The sequencer must never restart the divider in the middle of a division.
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider restarted while busy");

endmodule

`default_nettype wire
